@@ rtl/core/gnsk_pkg.sv @@
// shared types, codes and character helpers for the name soundex key block
package gnsk_pkg;

	// default longest stripped surname that still gets a real code
	localparam int MaxNameLen = 255;

	// ascii constants
	localparam logic [7:0] AsciiNul    = 8'h00;
	localparam logic [7:0] AsciiSlash  = 8'h2F;
	localparam logic [7:0] AsciiDollar = 8'h24;
	localparam logic [7:0] AsciiZ      = 8'h5A;
	localparam logic [5:0] Digit0      = 6'h30;
	localparam logic [5:0] Digit9      = 6'h39;

	// first initial tracker phases
	localparam logic [1:0] IpSeek    = 2'd0;
	localparam logic [1:0] IpInSlash = 2'd1;
	localparam logic [1:0] IpDone    = 2'd2;

	// surname coder phases
	localparam logic [2:0] SpBefore    = 3'd0;
	localparam logic [2:0] SpSkipWhite = 3'd1;
	localparam logic [2:0] SpIn        = 3'd2;
	localparam logic [2:0] SpClosed    = 3'd3;
	localparam logic [2:0] SpInvalid   = 3'd4;

	// one input request: a character and the end-of-name mark
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} req_t;

	// one finished key
	typedef struct packed {
		logic [7:0] key_initial;
		logic [7:0] key_letter;
		logic [5:0] key_digit_one;
		logic [5:0] key_digit_two;
		logic [5:0] key_digit_three;
	} key_t;

	// per-character control from the input stage to the trackers
	typedef struct packed {
		logic step;
		logic done;
	} step_ctl_t;

	function automatic logic is_white(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
	endfunction

	// soundex class of an upper-case character, zero for everything else
	function automatic logic [2:0] sound_code(input logic [7:0] c);
		logic [2:0] code;
		unique case (c)
			8'h42, 8'h46, 8'h50, 8'h56: code = 3'd1;
			8'h43, 8'h47, 8'h4A, 8'h4B,
			8'h51, 8'h53, 8'h58, 8'h5A: code = 3'd2;
			8'h44, 8'h54: code = 3'd3;
			8'h4C: code = 3'd4;
			8'h4D, 8'h4E: code = 3'd5;
			8'h52: code = 3'd6;
			default: code = 3'd0;
		endcase
		return code;
	endfunction

endpackage

@@ rtl/core/gnsk_in_stage.sv @@
// input register stage: holds one character request and paces the trackers
module gnsk_in_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gnsk_pkg::req_t       req,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic                 hold,
	output gnsk_pkg::step_ctl_t  ctl,
	output logic [7:0]           ch
);

	logic           valid_s1;
	gnsk_pkg::req_t req_s1;
	logic           blocked;

	// a final character waits only while the previous key is still unread
	assign blocked   = valid_s1 && req_s1.last && hold;
	assign req_stall = blocked;
	assign ctl.step  = valid_s1 && !blocked;
	assign ctl.done  = req_s1.last;
	assign ch        = req_s1.ch;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!blocked) begin
			valid_s1 <= req_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (!blocked && req_valid) begin
			req_s1 <= req;
		end
	end

endmodule

@@ rtl/core/gnsk_initial.sv @@
// first initial tracker: finds the first non-white character outside slash pairs
module gnsk_initial (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gnsk_pkg::step_ctl_t  ctl,
	input  logic [7:0]           ch,
	output logic [7:0]           key_initial
);

	logic [1:0] phase_q;
	logic [1:0] phase_d;
	logic [7:0] char_q;
	logic [7:0] char_d;

	// next state for this character
	always_comb begin
		phase_d = phase_q;
		char_d  = char_q;
		unique case (phase_q)
			gnsk_pkg::IpSeek: begin
				if (!gnsk_pkg::is_white(ch)) begin
					if (ch == gnsk_pkg::AsciiSlash) begin
						phase_d = gnsk_pkg::IpInSlash;
					end else begin
						char_d  = gnsk_pkg::is_letter(ch) ? gnsk_pkg::to_upper(ch)
						                                  : gnsk_pkg::AsciiDollar;
						phase_d = gnsk_pkg::IpDone;
					end
				end
			end
			gnsk_pkg::IpInSlash: begin
				if (ch == gnsk_pkg::AsciiNul) begin
					char_d  = gnsk_pkg::AsciiDollar;
					phase_d = gnsk_pkg::IpDone;
				end else if (ch == gnsk_pkg::AsciiSlash) begin
					phase_d = gnsk_pkg::IpSeek;
				end
			end
			default: begin
			end
		endcase
	end

	// key character including the current one
	assign key_initial = (phase_d == gnsk_pkg::IpDone) ? char_d : gnsk_pkg::AsciiDollar;

	// state registers, back to seeking after the final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= gnsk_pkg::IpSeek;
			char_q  <= gnsk_pkg::AsciiDollar;
		end else if (ctl.step) begin
			if (ctl.done) begin
				phase_q <= gnsk_pkg::IpSeek;
				char_q  <= gnsk_pkg::AsciiDollar;
			end else begin
				phase_q <= phase_d;
				char_q  <= char_d;
			end
		end
	end

endmodule

@@ rtl/core/gnsk_surname.sv @@
// surname coder: soundex letter and three digits of the first slash-delimited surname
module gnsk_surname #(
	parameter int MAX_NAME_LEN = gnsk_pkg::MaxNameLen
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gnsk_pkg::step_ctl_t  ctl,
	input  logic [7:0]           ch,
	output logic [7:0]           key_letter,
	output logic [5:0]           key_digit_one,
	output logic [5:0]           key_digit_two,
	output logic [5:0]           key_digit_three
);

	// length counters saturate at one past the limit
	localparam int LenW = $clog2(MAX_NAME_LEN + 2);
	localparam logic [LenW-1:0] LenMax = LenW'(MAX_NAME_LEN);

	logic [2:0]      phase_q, phase_d;
	logic [7:0]      first_q, first_d;
	logic [1:0]      count_q, count_d;
	logic [2:0]      store_q [3];
	logic [2:0]      store_d [3];
	logic [2:0]      prev_q, prev_d;
	logic [LenW-1:0] len_q, len_d;
	logic [LenW-1:0] trim_q, trim_d;
	logic [2:0]      code;
	logic            surname_ok;

	// next state for this character
	always_comb begin
		phase_d = phase_q;
		first_d = first_q;
		count_d = count_q;
		store_d = store_q;
		prev_d  = prev_q;
		len_d   = len_q;
		trim_d  = trim_q;
		code    = gnsk_pkg::sound_code(gnsk_pkg::to_upper(ch));
		unique case (phase_q)
			gnsk_pkg::SpBefore: begin
				if (ch == gnsk_pkg::AsciiSlash) begin
					phase_d = gnsk_pkg::SpSkipWhite;
				end else if (ch == gnsk_pkg::AsciiNul) begin
					phase_d = gnsk_pkg::SpInvalid;
				end
			end
			gnsk_pkg::SpSkipWhite: begin
				if (!gnsk_pkg::is_white(ch)) begin
					if (!gnsk_pkg::is_letter(ch)) begin
						phase_d = gnsk_pkg::SpInvalid;
					end else begin
						first_d = gnsk_pkg::to_upper(ch);
						len_d   = LenW'(1);
						trim_d  = LenW'(1);
						prev_d  = 3'd0;
						phase_d = gnsk_pkg::SpIn;
					end
				end
			end
			gnsk_pkg::SpIn: begin
				if (ch == gnsk_pkg::AsciiNul || ch == gnsk_pkg::AsciiSlash) begin
					phase_d = gnsk_pkg::SpClosed;
				end else begin
					if (len_q <= LenMax) begin
						len_d = len_q + LenW'(1);
					end
					if (!gnsk_pkg::is_white(ch)) begin
						trim_d = len_d;
					end
					// vowels, h, w and non-letters break a run of equal codes
					if (code == 3'd0) begin
						prev_d = 3'd0;
					end else if (code != prev_q) begin
						prev_d = code;
						if (count_q != 2'd3) begin
							store_d[count_q] = code;
							count_d          = count_q + 2'd1;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// key characters two to five including the current character
	assign surname_ok = (phase_d == gnsk_pkg::SpIn || phase_d == gnsk_pkg::SpClosed)
	                    && (trim_d <= LenMax);
	assign key_letter      = surname_ok ? first_d : gnsk_pkg::AsciiZ;
	assign key_digit_one   = !surname_ok ? gnsk_pkg::Digit9 :
	                         (count_d > 2'd0) ? gnsk_pkg::Digit0 + {3'b000, store_d[0]}
	                                          : gnsk_pkg::Digit0;
	assign key_digit_two   = !surname_ok ? gnsk_pkg::Digit9 :
	                         (count_d > 2'd1) ? gnsk_pkg::Digit0 + {3'b000, store_d[1]}
	                                          : gnsk_pkg::Digit0;
	assign key_digit_three = !surname_ok ? gnsk_pkg::Digit9 :
	                         (count_d > 2'd2) ? gnsk_pkg::Digit0 + {3'b000, store_d[2]}
	                                          : gnsk_pkg::Digit0;

	// state registers, cleared after the final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= gnsk_pkg::SpBefore;
			first_q <= 8'd0;
			count_q <= 2'd0;
			store_q <= '{3'd0, 3'd0, 3'd0};
			prev_q  <= 3'd0;
			len_q   <= '0;
			trim_q  <= '0;
		end else if (ctl.step) begin
			if (ctl.done) begin
				phase_q <= gnsk_pkg::SpBefore;
				first_q <= 8'd0;
				count_q <= 2'd0;
				store_q <= '{3'd0, 3'd0, 3'd0};
				prev_q  <= 3'd0;
				len_q   <= '0;
				trim_q  <= '0;
			end else begin
				phase_q <= phase_d;
				first_q <= first_d;
				count_q <= count_d;
				store_q <= store_d;
				prev_q  <= prev_d;
				len_q   <= len_d;
				trim_q  <= trim_d;
			end
		end
	end

	// trimmed length only ever copies the running length
	assert property (@(posedge clk) disable iff (!arst_n) trim_q <= len_q)
		else $error("trimmed surname length above running length");

	// no digits are collected before a surname has started
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != gnsk_pkg::SpIn && phase_q != gnsk_pkg::SpClosed) |-> count_q == 2'd0)
		else $error("soundex digits present outside a surname");

endmodule

@@ rtl/core/gedcom_name_soundex_key.sv @@
// top level of the name soundex key block: input stage, trackers and key register
//
// Takes a name one character per request and, on the request marked last,
// delivers one five-character key: the first initial, then the soundex letter
// and three digits of the first slash-delimited surname (Z999 if the surname
// is missing, invalid or longer than MAX_NAME_LEN after trailing white space).
// One character is taken every cycle unless the input side stalls. A character
// sits in the input register while the trackers work out their next state;
// when it steps on, the trackers update and, for a final character, the key
// register loads from the input register's final character. A final character
// waits in the input register only while the previous key is stalled; other
// characters keep flowing.
module gedcom_name_soundex_key #(
	parameter int MAX_NAME_LEN = gnsk_pkg::MaxNameLen
) (
	input  logic           clk,
	input  logic           arst_n,
	input  gnsk_pkg::req_t req,
	input  logic           req_valid,
	output logic           req_stall,
	output gnsk_pkg::key_t key,
	output logic           key_valid,
	input  logic           key_stall
);

	gnsk_pkg::step_ctl_t ctl;
	logic [7:0]          ch;
	logic                hold;
	gnsk_pkg::key_t      key_d;
	gnsk_pkg::key_t      key_q;
	logic                key_valid_q;

	assign hold = key_valid_q && key_stall;

	// input register
	gnsk_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.hold      (hold),
		.ctl       (ctl),
		.ch        (ch)
	);

	// first initial
	gnsk_initial u_initial (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.ch          (ch),
		.key_initial (key_d.key_initial)
	);

	// surname code
	gnsk_surname #(
		.MAX_NAME_LEN (MAX_NAME_LEN)
	) u_surname (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.ch              (ch),
		.key_letter      (key_d.key_letter),
		.key_digit_one   (key_d.key_digit_one),
		.key_digit_two   (key_d.key_digit_two),
		.key_digit_three (key_d.key_digit_three)
	);

	// key register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_valid_q <= 1'b0;
		end else if (ctl.step && ctl.done) begin
			key_valid_q <= 1'b1;
		end else if (!key_stall) begin
			key_valid_q <= 1'b0;
		end
	end

	// key register payload
	always_ff @(posedge clk) begin
		if (ctl.step && ctl.done) begin
			key_q <= key_d;
		end
	end

	assign key       = key_q;
	assign key_valid = key_valid_q;

	// a final character always produces a key on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.step && ctl.done) |=> key_valid)
		else $error("final character did not load a key");

	// an unread key is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(key_valid && key_stall) |-> !(ctl.step && ctl.done))
		else $error("key overwritten while stalled");

	// the input side only stalls behind a stalled key
	assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (key_valid && key_stall))
		else $error("input stalled without a stalled key");

endmodule

@@ sim/tb_gedcom_name_soundex_key.sv @@
// testbench for the name soundex key block: predicted keys checked against every delivered key
`timescale 1ns / 100ps

module tb_gedcom_name_soundex_key;

	localparam int IdleLimit = 1000;
	localparam int RandChars = 500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	gnsk_pkg::req_t req = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	gnsk_pkg::key_t key;
	logic key_valid;
	logic key_stall = 1'b0;

	gedcom_name_soundex_key DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.key      (key),
		.key_valid(key_valid),
		.key_stall(key_stall)
	);

	always #5 clk = ~clk;

	// keys predicted for names already sent, oldest first
	gnsk_pkg::key_t pending_keys[$];
	logic [7:0] name_buf[$];
	int errors = 0;
	int sent = 0;
	int idle_cycles = 0;
	logic calm = 1'b0;

	// predicted tracker state
	logic [1:0] init_phase;
	logic [7:0] init_char;
	logic [2:0] sur_phase;
	logic [7:0] sur_first;
	int n_digits;
	logic [2:0] digits[3];
	logic [2:0] prev_code;
	int sur_len;
	int trim_len;

	function automatic logic white_char(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic alpha_char(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic [7:0] upcase(input logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'd32 : c;
	endfunction

	function automatic logic [2:0] soundex_class(input logic [7:0] c);
		case (c)
			"B", "F", "P", "V": return 3'd1;
			"C", "G", "J", "K", "Q", "S", "X", "Z": return 3'd2;
			"D", "T": return 3'd3;
			"L": return 3'd4;
			"M", "N": return 3'd5;
			"R": return 3'd6;
			default: return 3'd0;
		endcase
	endfunction

	function automatic void clear_tracker();
		init_phase = gnsk_pkg::IpSeek;
		init_char = gnsk_pkg::AsciiDollar;
		sur_phase = gnsk_pkg::SpBefore;
		sur_first = '0;
		n_digits = 0;
		digits[0] = '0;
		digits[1] = '0;
		digits[2] = '0;
		prev_code = '0;
		sur_len = 0;
		trim_len = 0;
	endfunction

	// advance the predicted state by one character, queue a key on the final one
	function automatic void track_char(input logic [7:0] c, input logic fin);
		logic [2:0] code;
		gnsk_pkg::key_t k;
		// first initial
		case (init_phase)
			gnsk_pkg::IpSeek: if (!white_char(c)) begin
				if (c == gnsk_pkg::AsciiSlash) begin
					init_phase = gnsk_pkg::IpInSlash;
				end else begin
					init_char = alpha_char(c) ? upcase(c) : gnsk_pkg::AsciiDollar;
					init_phase = gnsk_pkg::IpDone;
				end
			end
			gnsk_pkg::IpInSlash: if (c == gnsk_pkg::AsciiNul) begin
				init_char = gnsk_pkg::AsciiDollar;
				init_phase = gnsk_pkg::IpDone;
			end else if (c == gnsk_pkg::AsciiSlash) begin
				init_phase = gnsk_pkg::IpSeek;
			end
			default: ;
		endcase
		// surname code
		case (sur_phase)
			gnsk_pkg::SpBefore: if (c == gnsk_pkg::AsciiSlash) begin
				sur_phase = gnsk_pkg::SpSkipWhite;
			end else if (c == gnsk_pkg::AsciiNul) begin
				sur_phase = gnsk_pkg::SpInvalid;
			end
			gnsk_pkg::SpSkipWhite: if (!white_char(c)) begin
				if (!alpha_char(c)) begin
					sur_phase = gnsk_pkg::SpInvalid;
				end else begin
					sur_first = upcase(c);
					sur_len = 1;
					trim_len = 1;
					prev_code = '0;
					sur_phase = gnsk_pkg::SpIn;
				end
			end
			gnsk_pkg::SpIn: if (c == gnsk_pkg::AsciiNul || c == gnsk_pkg::AsciiSlash) begin
				sur_phase = gnsk_pkg::SpClosed;
			end else begin
				if (sur_len <= gnsk_pkg::MaxNameLen) sur_len++;
				if (!white_char(c)) trim_len = sur_len;
				code = soundex_class(upcase(c));
				if (code == 3'd0) begin
					prev_code = '0;
				end else if (code != prev_code) begin
					prev_code = code;
					if (n_digits < 3) begin
						digits[n_digits] = code;
						n_digits++;
					end
				end
			end
			default: ;
		endcase
		if (fin) begin
			k.key_initial = (init_phase == gnsk_pkg::IpDone) ? init_char
			                                                  : gnsk_pkg::AsciiDollar;
			if ((sur_phase == gnsk_pkg::SpIn || sur_phase == gnsk_pkg::SpClosed) &&
			    trim_len <= gnsk_pkg::MaxNameLen) begin
				k.key_letter = sur_first;
				k.key_digit_one = (n_digits > 0) ? gnsk_pkg::Digit0 + 6'(digits[0])
				                                 : gnsk_pkg::Digit0;
				k.key_digit_two = (n_digits > 1) ? gnsk_pkg::Digit0 + 6'(digits[1])
				                                 : gnsk_pkg::Digit0;
				k.key_digit_three = (n_digits > 2) ? gnsk_pkg::Digit0 + 6'(digits[2])
				                                   : gnsk_pkg::Digit0;
			end else begin
				k.key_letter = gnsk_pkg::AsciiZ;
				k.key_digit_one = gnsk_pkg::Digit9;
				k.key_digit_two = gnsk_pkg::Digit9;
				k.key_digit_three = gnsk_pkg::Digit9;
			end
			pending_keys.push_back(k);
			clear_tracker();
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		errors++;
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
	endtask

	// one character request, with a random gap in front
	task automatic send_char(input logic [7:0] c, input logic fin);
		int gap;
		gnsk_pkg::req_t r;
		gap = calm ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		r.ch = c;
		r.last = fin;
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		track_char(c, fin);
		sent++;
		@(negedge clk);
	endtask

	function automatic void put_text(input string s);
		for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
	endfunction

	task automatic send_name();
		int n;
		n = name_buf.size();
		for (int i = 0; i < n; i++) send_char(name_buf[i], i == n - 1);
		name_buf.delete();
	endtask

	task automatic wait_for_keys();
		req_valid <= 1'b0;
		while (pending_keys.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [7:0] white_pick();
		int unsigned r;
		r = $urandom_range(9, 14);
		return (r == 14) ? 8'd32 : 8'(r);
	endfunction

	function automatic logic [7:0] letter_pick(input string set);
		logic [7:0] c;
		c = set[$urandom_range(0, set.len() - 1)];
		return $urandom_range(0, 1) ? (c | 8'h20) : c;
	endfunction

	// surname content: mostly coded letters, some separators
	function automatic logic [7:0] surname_pick();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return letter_pick("BFPVCGJKQSXZDTLMNR");
		if (r < 85) return letter_pick("AEIOUYHW");
		if (r < 92) return white_pick();
		return 8'($urandom_range(33, 126));
	endfunction

	// key side stall: random hold before each key, then wait for it
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = calm ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				key_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			key_stall <= 1'b0;
			do @(posedge clk); while (!(key_valid && !key_stall));
		end
	end

	// compare each delivered key with the oldest prediction
	always @(posedge clk) begin : key_check
		gnsk_pkg::key_t want;
		if (arst_n && key_valid && !key_stall) begin
			if (pending_keys.size() == 0) begin
				report_mismatch("unexpected key", 64'(key), 64'd0);
			end else begin
				want = pending_keys.pop_front();
				if (key.key_initial != want.key_initial)
					report_mismatch("key_initial", 64'(key.key_initial),
						64'(want.key_initial));
				if (key.key_letter != want.key_letter)
					report_mismatch("key_letter", 64'(key.key_letter),
						64'(want.key_letter));
				if (key.key_digit_one != want.key_digit_one)
					report_mismatch("key_digit_one", 64'(key.key_digit_one),
						64'(want.key_digit_one));
				if (key.key_digit_two != want.key_digit_two)
					report_mismatch("key_digit_two", 64'(key.key_digit_two),
						64'(want.key_digit_two));
				if (key.key_digit_three != want.key_digit_three)
					report_mismatch("key_digit_three", 64'(key.key_digit_three),
						64'(want.key_digit_three));
			end
		end
	end

	// watchdog on cycles with no request and no key accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (key_valid && !key_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// short names over the special cases and character extremes
	task automatic test_directed();
		// first letter does not suppress an equal code
		put_text("j/Pfv/");
		send_name();
		// non-letter at surname start, no initial outside slashes
		put_text("/ 1/");
		send_name();
		// no slash at all
		put_text("x");
		send_name();
		// zero inside the slash pair ends the name
		put_text("/Ab");
		name_buf.push_back(gnsk_pkg::AsciiNul);
		put_text("Q");
		send_name();
		// unclosed surname, initial never decided
		put_text("/Lee");
		send_name();
		// top character value alone
		name_buf.push_back(8'hFF);
		send_name();
		// zero on the final character
		put_text("/z");
		name_buf.push_back(gnsk_pkg::AsciiNul);
		send_name();
	endtask

	// surnames around the length limit, with trailing white, one past saturation
	task automatic test_surname_length();
		int body[2] = '{255, 257};
		int tail[2] = '{6, 2};
		calm = 1'b1;
		for (int t = 0; t < 2; t++) begin
			put_text("k /");
			name_buf.push_back(letter_pick("BCDLMRST"));
			for (int i = 1; i < body[t]; i++) name_buf.push_back(letter_pick("BAHLRW"));
			for (int i = 0; i < tail[t]; i++) name_buf.push_back(white_pick());
			put_text("/");
			send_name();
		end
		calm = 1'b0;
	endtask

	// mostly well-formed names with random content, some noise
	task automatic test_random_names();
		int start;
		int unsigned mode;
		logic drained;
		start = sent;
		drained = 1'b0;
		while (sent - start < RandChars) begin
			calm = ($urandom_range(0, 7) == 0);
			mode = $urandom_range(0, 99);
			if (mode < 80) begin
				repeat ($urandom_range(0, 2)) name_buf.push_back(white_pick());
				repeat ($urandom_range(0, 5))
					name_buf.push_back($urandom_range(0, 9) == 0 ?
						8'($urandom_range(33, 126)) : letter_pick("ABCDEFGHIJKLMNOPQRSTUVWXYZ"));
				name_buf.push_back(8'd32);
				if ($urandom_range(0, 9) != 0) name_buf.push_back(gnsk_pkg::AsciiSlash);
				repeat ($urandom_range(0, 2)) name_buf.push_back(white_pick());
				// broken surname start now and then
				if ($urandom_range(0, 19) == 0)
					name_buf.push_back($urandom_range(0, 1) ? gnsk_pkg::AsciiSlash :
						8'($urandom_range(0, 64)));
				name_buf.push_back(letter_pick("ABCDEFGHIJKLMNOPQRSTUVWXYZ"));
				repeat ($urandom_range(0, 9)) name_buf.push_back(surname_pick());
				repeat ($urandom_range(0, 2)) name_buf.push_back(white_pick());
				if ($urandom_range(0, 6) != 0) name_buf.push_back(gnsk_pkg::AsciiSlash);
				repeat ($urandom_range(0, 3)) name_buf.push_back(letter_pick("JRSIV"));
			end else begin
				repeat ($urandom_range(1, 8))
					name_buf.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) :
						(($urandom_range(0, 4) == 0) ? gnsk_pkg::AsciiNul
						                             : letter_pick("/ aB")));
			end
			send_name();
			// hold off once until every key is out
			if (!drained && sent - start >= RandChars / 2) begin
				wait_for_keys();
				drained = 1'b1;
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		clear_tracker();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_surname_length();
		test_random_names();
		wait_for_keys();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
